### rtl/mrfb_pkg.sv
// Shared constants, queue entry type and checksum helper for the
// multicast report frame builder. No dependencies.

package mrfb_pkg;

  localparam int MIN_FRAME_BYTES = 60;
  localparam int IGMP_RAW_LEN    = 46;
  localparam int MLD_RAW_LEN     = 86;

  localparam int IGMP_LEN        = (IGMP_RAW_LEN > MIN_FRAME_BYTES) ? IGMP_RAW_LEN
                                                                    : MIN_FRAME_BYTES;
  localparam int IGMP_WORDS      = (IGMP_LEN + 7) / 8;
  localparam int IGMP_LAST_BYTES = IGMP_LEN - 8 * (IGMP_WORDS - 1);
  localparam int MLD_WORDS       = (MLD_RAW_LEN + 7) / 8;
  localparam int MLD_LAST_BYTES  = MLD_RAW_LEN - 8 * (MLD_WORDS - 1);
  localparam int MAX_WORDS       = MLD_WORDS;
  localparam int WIDX_W          = $clog2(MAX_WORDS);

  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

  localparam int PART_W          = 19;
  localparam int SUM_W           = 22;

  localparam logic [23:0] V4_MAC_PREFIX    = 24'h01005e;
  localparam logic [15:0] V6_MAC_PREFIX    = 16'h3333;
  localparam logic [15:0] ETH_TYPE_IPV4    = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6    = 16'h86dd;
  localparam logic [7:0]  IPV4_VER_IHL     = 8'h46;
  localparam logic [7:0]  IPV4_TOS         = 8'hc0;
  localparam logic [15:0] IPV4_TOTAL_LEN   = 16'd32;
  localparam logic [7:0]  IPV4_TTL         = 8'd1;
  localparam logic [7:0]  PROTO_IGMP       = 8'd2;
  localparam logic [15:0] IPV4_OPT_RA      = 16'h9404;
  localparam logic [7:0]  IGMP_V2_REPORT   = 8'h16;
  localparam logic [7:0]  IPV6_VER         = 8'h60;
  localparam logic [15:0] IPV6_PAYLOAD_LEN = 16'd32;
  localparam logic [7:0]  NH_HOP_BY_HOP    = 8'd0;
  localparam logic [7:0]  IPV6_HOP_LIMIT   = 8'd1;
  localparam logic [7:0]  NH_ICMPV6        = 8'd58;
  localparam logic [15:0] HBH_OPT_RA       = 16'h0502;
  localparam logic [15:0] HBH_PADN         = 16'h0100;
  localparam logic [7:0]  MLD_V1_REPORT    = 8'd131;
  localparam logic [15:0] MLD_MSG_LEN      = 16'd24;
  localparam logic [9:0]  LINK_LOCAL_PFX   = 10'h3fa;

  // constant words of the IPv4 header and of the ICMPv6 pseudo-header + message
  localparam logic [SUM_W-1:0] IPV4_HDR_CONST =
    SUM_W'({IPV4_VER_IHL, IPV4_TOS}) + SUM_W'(IPV4_TOTAL_LEN) +
    SUM_W'({IPV4_TTL, PROTO_IGMP}) + SUM_W'(IPV4_OPT_RA);
  localparam logic [SUM_W-1:0] MLD_CSUM_CONST =
    SUM_W'({MLD_V1_REPORT, 8'h00}) + SUM_W'(MLD_MSG_LEN) + SUM_W'(NH_ICMPV6);

  typedef struct packed {
    logic        is_ipv6;
    logic [47:0] src_mac;
    logic [31:0] src_ipv4;
    logic [63:0] src_ipv6_hi;
    logic [63:0] src_ipv6_lo;
    logic [31:0] group_v4;
    logic [63:0] group_v6_hi;
    logic [63:0] group_v6_lo;
    logic [15:0] hdr_csum;
    logic [15:0] igmp_csum;
  } mrfb_job_t;

  function automatic logic [15:0] fold_csum(input logic [SUM_W-1:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = 17'(s[15:0]) + 17'(s[SUM_W-1:16]);
    s2 = 17'(s1[15:0]) + 17'(s1[16]);
    return ~s2[15:0];
  endfunction

endpackage

### rtl/mrfb_in_if.sv
// Request channel of the multicast report frame builder: valid/ready
// plus one endpoint record. No dependencies.

interface mrfb_in_if;
  logic        valid;
  logic        ready;
  logic        endpoint_up;
  logic        is_ipv6;
  logic [47:0] src_mac;
  logic [31:0] src_ipv4;
  logic [63:0] src_ipv6_hi;
  logic [63:0] src_ipv6_lo;
  logic [31:0] group_v4;
  logic [63:0] group_v6_hi;
  logic [63:0] group_v6_lo;

  modport source (
    output valid, endpoint_up, is_ipv6, src_mac, src_ipv4, src_ipv6_hi, src_ipv6_lo,
           group_v4, group_v6_hi, group_v6_lo,
    input  ready
  );
  modport sink (
    input  valid, endpoint_up, is_ipv6, src_mac, src_ipv4, src_ipv6_hi, src_ipv6_lo,
           group_v4, group_v6_hi, group_v6_lo,
    output ready
  );
endinterface

### rtl/mrfb_out_if.sv
// Frame word channel of the multicast report frame builder: valid/ready
// plus one 64-bit word with byte count and last flag. No dependencies.

interface mrfb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_word;
  logic [3:0]  word_bytes;
  logic        last_word;

  modport source (output valid, frame_word, word_bytes, last_word, input ready);
  modport sink   (input valid, frame_word, word_bytes, last_word, output ready);
endinterface

### rtl/mrfb_front.sv
// Front end: accepts endpoint records, drops unusable ones, computes the
// header checksums and pushes a job into the queue. Uses mrfb_pkg, mrfb_in_if.

module mrfb_front
  import mrfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mrfb_in_if.sink    in_ch,
  input  logic       q_full,
  output logic       push,
  output mrfb_job_t  push_job
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_SUM  = 4'b0010,
    F_FOLD = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t state, state_next;
  mrfb_job_t    job;
  logic [PART_W-1:0] part [4];
  logic [PART_W-1:0] part_next [4];
  logic [17:0]  igmp_sum;
  logic         keep;
  logic [SUM_W-1:0] total;

  assign in_ch.ready = (state == F_IDLE);
  assign push        = (state == F_PUSH) && !q_full;
  assign push_job    = job;

  assign keep = in_ch.endpoint_up &&
                (in_ch.is_ipv6 ? (in_ch.src_ipv6_hi[63:54] == LINK_LOCAL_PFX)
                               : (in_ch.src_ipv4 != 32'd0));

  always_comb begin
    if (job.is_ipv6) begin
      part_next[0] = PART_W'(job.src_ipv6_hi[63:48]) + PART_W'(job.src_ipv6_hi[47:32]) +
                     PART_W'(job.src_ipv6_hi[31:16]) + PART_W'(job.src_ipv6_hi[15:0]);
      part_next[1] = PART_W'(job.src_ipv6_lo[63:48]) + PART_W'(job.src_ipv6_lo[47:32]) +
                     PART_W'(job.src_ipv6_lo[31:16]) + PART_W'(job.src_ipv6_lo[15:0]);
      // group words are covered twice: in the pseudo-header and in the message
      part_next[2] = PART_W'({job.group_v6_hi[63:48], 1'b0}) +
                     PART_W'({job.group_v6_hi[47:32], 1'b0}) +
                     PART_W'({job.group_v6_hi[31:16], 1'b0}) +
                     PART_W'({job.group_v6_hi[15:0], 1'b0});
      part_next[3] = PART_W'({job.group_v6_lo[63:48], 1'b0}) +
                     PART_W'({job.group_v6_lo[47:32], 1'b0}) +
                     PART_W'({job.group_v6_lo[31:16], 1'b0}) +
                     PART_W'({job.group_v6_lo[15:0], 1'b0});
    end else begin
      part_next[0] = PART_W'(job.src_ipv4[31:16]) + PART_W'(job.src_ipv4[15:0]) +
                     PART_W'(job.group_v4[31:16]) + PART_W'(job.group_v4[15:0]);
      part_next[1] = '0;
      part_next[2] = '0;
      part_next[3] = '0;
    end
  end

  assign total = SUM_W'(part[0]) + SUM_W'(part[1]) + SUM_W'(part[2]) + SUM_W'(part[3]) +
                 (job.is_ipv6 ? MLD_CSUM_CONST : IPV4_HDR_CONST);

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (in_ch.valid && keep) state_next = F_SUM;
      F_SUM:  state_next = F_FOLD;
      F_FOLD: state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_ch.valid) begin
          job.is_ipv6     <= in_ch.is_ipv6;
          job.src_mac     <= in_ch.src_mac;
          job.src_ipv4    <= in_ch.src_ipv4;
          job.src_ipv6_hi <= in_ch.src_ipv6_hi;
          job.src_ipv6_lo <= in_ch.src_ipv6_lo;
          job.group_v4    <= in_ch.group_v4;
          job.group_v6_hi <= in_ch.group_v6_hi;
          job.group_v6_lo <= in_ch.group_v6_lo;
        end
      end
      F_SUM: begin
        part     <= part_next;
        igmp_sum <= 18'({IGMP_V2_REPORT, 8'h00}) + 18'(job.group_v4[31:16]) +
                    18'(job.group_v4[15:0]);
      end
      F_FOLD: begin
        job.hdr_csum  <= fold_csum(total);
        job.igmp_csum <= fold_csum(SUM_W'(igmp_sum));
      end
      default: ;
    endcase
  end

endmodule

### rtl/mrfb_queue.sv
// Short job queue between front and back ends of the frame builder.
// Uses mrfb_pkg.

module mrfb_queue
  import mrfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  mrfb_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output mrfb_job_t head
);

  mrfb_job_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr;
  logic [QUEUE_AW-1:0]     rd_ptr;
  logic [QUEUE_AW:0]       count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/mrfb_back.sv
// Back end: walks the head job word by word and drives the output register.
// Uses mrfb_pkg, mrfb_out_if.

module mrfb_back
  import mrfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  mrfb_job_t  head,
  output logic       pop,
  mrfb_out_if.source out_ch
);

  logic [WIDX_W-1:0] idx;
  logic              load;
  logic              is_last;
  logic [63:0]       word;
  logic [3:0]        nbytes;

  assign load    = !out_ch.valid || out_ch.ready;
  assign is_last = head.is_ipv6 ? (idx == WIDX_W'(MLD_WORDS - 1))
                                : (idx == WIDX_W'(IGMP_WORDS - 1));
  assign pop     = load && !empty && is_last;

  always_comb begin
    if (!is_last) begin
      nbytes = 4'd8;
    end else if (head.is_ipv6) begin
      nbytes = 4'(MLD_LAST_BYTES);
    end else begin
      nbytes = 4'(IGMP_LAST_BYTES);
    end
  end

  always_comb begin
    word = '0;
    if (head.is_ipv6) begin
      case (idx)
        WIDX_W'(0):  word = {V6_MAC_PREFIX, head.group_v6_lo[31:0], head.src_mac[47:32]};
        WIDX_W'(1):  word = {head.src_mac[31:0], ETH_TYPE_IPV6, IPV6_VER, 8'h00};
        WIDX_W'(2):  word = {16'h0000, IPV6_PAYLOAD_LEN, NH_HOP_BY_HOP, IPV6_HOP_LIMIT,
                             head.src_ipv6_hi[63:48]};
        WIDX_W'(3):  word = {head.src_ipv6_hi[47:0], head.src_ipv6_lo[63:48]};
        WIDX_W'(4):  word = {head.src_ipv6_lo[47:0], head.group_v6_hi[63:48]};
        WIDX_W'(5):  word = {head.group_v6_hi[47:0], head.group_v6_lo[63:48]};
        WIDX_W'(6):  word = {head.group_v6_lo[47:0], NH_ICMPV6, 8'h00};
        WIDX_W'(7):  word = {HBH_OPT_RA, 16'h0000, HBH_PADN, MLD_V1_REPORT, 8'h00};
        WIDX_W'(8):  word = {head.hdr_csum, 32'h0, head.group_v6_hi[63:48]};
        WIDX_W'(9):  word = {head.group_v6_hi[47:0], head.group_v6_lo[63:48]};
        WIDX_W'(10): word = {head.group_v6_lo[47:0], 16'h0000};
        default:     word = '0;
      endcase
    end else begin
      case (idx)
        WIDX_W'(0): word = {V4_MAC_PREFIX, 1'b0, head.group_v4[22:0], head.src_mac[47:32]};
        WIDX_W'(1): word = {head.src_mac[31:0], ETH_TYPE_IPV4, IPV4_VER_IHL, IPV4_TOS};
        WIDX_W'(2): word = {IPV4_TOTAL_LEN, 32'h0, IPV4_TTL, PROTO_IGMP};
        WIDX_W'(3): word = {head.hdr_csum, head.src_ipv4, head.group_v4[31:16]};
        WIDX_W'(4): word = {head.group_v4[15:0], IPV4_OPT_RA, 16'h0000,
                            IGMP_V2_REPORT, 8'h00};
        WIDX_W'(5): word = {head.igmp_csum, head.group_v4, 16'h0000};
        default:    word = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      out_ch.valid <= !empty;
      if (!empty) begin
        idx <= is_last ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_ch.frame_word <= word;
      out_ch.word_bytes <= nbytes;
      out_ch.last_word  <= is_last;
    end
  end

endmodule

### rtl/multicast_report_frame_builder_top.sv
// Multicast membership report frame builder, top level.
// Depends on mrfb_pkg, mrfb_in_if, mrfb_out_if, mrfb_front, mrfb_queue, mrfb_back.
//
// in_ch carries one endpoint record per transaction. A record that is down,
// an IPv4 record with a zero source, or an IPv6 record whose source is not
// link-local is taken by the front end and produces nothing. Any other record
// produces one frame on out_ch as 64-bit big-endian words: an IGMPv2 report
// padded to MIN_FRAME_BYTES (8 words at 60 bytes) or an 86-byte MLDv1 report
// (11 words). word_bytes gives the valid leading bytes; last_word marks the end.
// The front end takes a record, sums the checksum words, folds the two
// checksums and pushes the job into the queue before it takes the next; the
// back end sends one word per cycle while out_ch is ready. A two-entry job
// queue lets the front keep taking records while the back end drains a
// frame. When out_ch stalls, the current word is held and the back end
// waits; the front fills the queue and then drops ready.
// Synchronous reset empties the queue and pipeline and discards any frame
// in progress.

module multicast_report_frame_builder_top
  import mrfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mrfb_in_if.sink    in_ch,
  mrfb_out_if.source out_ch
);

  logic      push;
  logic      pop;
  logic      full;
  logic      empty;
  mrfb_job_t push_job;
  mrfb_job_t head;

  mrfb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_full   (full),
    .push     (push),
    .push_job (push_job)
  );

  mrfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  mrfb_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

### bench/mrfb_report_checker.sv
// Frame checker for the multicast report frame builder: watches both channels,
// predicts every report frame word by word and compares what leaves the block.
// Depends on the mrfb_in_if and mrfb_out_if interfaces.
`timescale 1ns / 1ps

module mrfb_report_checker (
  input  logic clk,
  input  logic rst,
  mrfb_in_if   req,
  mrfb_out_if  frm,
  output int   fail_count,
  output int   pending_words
);

  localparam int MIN_FRAME_LEN = 60;
  localparam int IGMP_BYTES    = 46;
  localparam int MLD_BYTES     = 86;
  localparam int FRAME_BUF_LEN = 96;

  localparam logic [9:0]  LINK_LOCAL_TOP = 10'h3fa;
  localparam logic [15:0] ETHERTYPE_V4   = 16'h0800;
  localparam logic [15:0] ETHERTYPE_V6   = 16'h86dd;
  localparam logic [7:0]  IGMP_REPORT_V2 = 8'h16;
  localparam logic [7:0]  MLD_REPORT_V1  = 8'd131;
  localparam logic [7:0]  NEXT_HDR_ICMP6 = 8'd58;
  localparam int          MLD_MSG_BYTES  = 24;

  typedef struct packed {
    logic [63:0] frame_word;
    logic [3:0]  word_bytes;
    logic        last_word;
  } frame_word_t;

  logic [7:0]  frame_bytes [FRAME_BUF_LEN];
  frame_word_t expected_words [$];
  int          frames_seen;
  int          word_in_frame;

  initial begin
    fail_count    = 0;
    pending_words = 0;
    frames_seen   = 0;
    word_in_frame = 0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch, frame %0d word %0d: %s", frames_seen, word_in_frame, what);
    fail_count++;
  endtask

  function automatic void put_be(input int pos, input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++)
      frame_bytes[pos + i] = 8'(v >> (8 * (n - 1 - i)));
  endfunction

  function automatic int unsigned add_halfwords(input int first, input int len,
                                                input int unsigned acc);
    for (int i = 0; i + 1 < len; i += 2)
      acc += {16'h0, frame_bytes[first + i], frame_bytes[first + i + 1]};
    if (len % 2)
      acc += {16'h0, frame_bytes[first + len - 1], 8'h00};
    return acc;
  endfunction

  function automatic logic [15:0] inet_checksum(input int unsigned s);
    while (s >> 16)
      s = (s & 32'hffff) + (s >> 16);
    return ~s[15:0];
  endfunction

  function automatic void predict_report(
    input logic        up,
    input logic        v6,
    input logic [47:0] mac,
    input logic [31:0] src4,
    input logic [63:0] s6hi,
    input logic [63:0] s6lo,
    input logic [31:0] g4,
    input logic [63:0] g6hi,
    input logic [63:0] g6lo
  );
    int          len;
    int          nwords;
    int          cnt;
    int unsigned s;
    logic [63:0] w;
    if (!up)
      return;
    foreach (frame_bytes[i])
      frame_bytes[i] = 8'h00;
    if (!v6) begin
      if (src4 == '0)
        return;
      put_be(0, 64'h01005e, 3);
      frame_bytes[3] = {1'b0, g4[22:16]};
      put_be(4, 64'(g4[15:0]), 2);
      put_be(6, 64'(mac), 6);
      put_be(12, 64'(ETHERTYPE_V4), 2);
      put_be(14, 64'h46c0_0020, 4);
      put_be(22, 64'h0102, 2);
      put_be(26, 64'(src4), 4);
      put_be(30, 64'(g4), 4);
      put_be(34, 64'h9404, 2);
      frame_bytes[38] = IGMP_REPORT_V2;
      put_be(42, 64'(g4), 4);
      put_be(40, 64'(inet_checksum(add_halfwords(38, 8, 0))), 2);
      put_be(24, 64'(inet_checksum(add_halfwords(14, 24, 0))), 2);
      len = (IGMP_BYTES < MIN_FRAME_LEN) ? MIN_FRAME_LEN : IGMP_BYTES;
      if (len > FRAME_BUF_LEN)
        len = FRAME_BUF_LEN;
    end else begin
      if (s6hi[63:54] != LINK_LOCAL_TOP)
        return;
      put_be(0, 64'h3333, 2);
      put_be(2, 64'(g6lo[31:0]), 4);
      put_be(6, 64'(mac), 6);
      put_be(12, 64'(ETHERTYPE_V6), 2);
      frame_bytes[14] = 8'h60;
      put_be(18, 64'h0020, 2);
      frame_bytes[21] = 8'h01;
      put_be(22, s6hi, 8);
      put_be(30, s6lo, 8);
      put_be(38, g6hi, 8);
      put_be(46, g6lo, 8);
      frame_bytes[54] = NEXT_HDR_ICMP6;
      put_be(56, 64'h0502, 2);
      frame_bytes[60] = 8'h01;
      frame_bytes[62] = MLD_REPORT_V1;
      put_be(70, g6hi, 8);
      put_be(78, g6lo, 8);
      // pseudo-header: addresses, upper-layer length, next header
      s = add_halfwords(22, 32, 0) + MLD_MSG_BYTES + NEXT_HDR_ICMP6;
      put_be(64, 64'(inet_checksum(add_halfwords(62, 24, s))), 2);
      len = MLD_BYTES;
    end
    nwords = (len + 7) / 8;
    for (int k = 0; k < nwords; k++) begin
      cnt = len - 8 * k;
      if (cnt > 8)
        cnt = 8;
      w = '0;
      for (int i = 0; i < 8; i++)
        w = {w[55:0], (i < cnt) ? frame_bytes[8 * k + i] : 8'h00};
      expected_words.push_back('{w, 4'(cnt), k + 1 == nwords});
    end
  endfunction

  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    if (!rst) begin
      if (frm.valid && frm.ready) begin
        got = '{frm.frame_word, frm.word_bytes, frm.last_word};
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", got.frame_word));
        end else begin
          want = expected_words.pop_front();
          if (got.frame_word !== want.frame_word)
            report_mismatch($sformatf("frame_word %h, want %h",
                                      got.frame_word, want.frame_word));
          if (got.word_bytes !== want.word_bytes)
            report_mismatch($sformatf("word_bytes %0d, want %0d",
                                      got.word_bytes, want.word_bytes));
          if (got.last_word !== want.last_word)
            report_mismatch($sformatf("last_word %b, want %b",
                                      got.last_word, want.last_word));
        end
        if (got.last_word === 1'b1) begin
          frames_seen++;
          word_in_frame = 0;
        end else begin
          word_in_frame++;
        end
      end
      if (req.valid && req.ready)
        predict_report(req.endpoint_up, req.is_ipv6, req.src_mac, req.src_ipv4,
                       req.src_ipv6_hi, req.src_ipv6_lo, req.group_v4,
                       req.group_v6_hi, req.group_v6_lo);
    end
    pending_words = expected_words.size();
  end

endmodule

### bench/tb_multicast_report_frame_builder_top.sv
// Testbench top for multicast_report_frame_builder_top: drives endpoint
// records and receiver back-pressure, and gives the verdict.
// Depends on mrfb_in_if, mrfb_out_if, the block itself and mrfb_report_checker.
`timescale 1ns / 1ps

module tb_multicast_report_frame_builder_top;

  localparam int          ITEM_TARGET    = 333;
  localparam logic [9:0]  LINK_LOCAL_TOP = 10'h3fa;
  localparam logic [31:0] MDNS_V4        = 32'he00000fb;
  localparam logic [63:0] MDNS_V6_HI     = 64'hff02_0000_0000_0000;
  localparam logic [63:0] MDNS_V6_LO     = 64'h0000_0000_0000_00fb;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_TWO_OF_THREE} rx_mode_t;

  typedef struct {
    logic        up;
    logic        v6;
    logic [47:0] mac;
    logic [31:0] src4;
    logic [63:0] s6hi;
    logic [63:0] s6lo;
    logic [31:0] g4;
    logic [63:0] g6hi;
    logic [63:0] g6lo;
  } endpoint_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_words;
  int   burst_left;

  mrfb_in_if  in_ch ();
  mrfb_out_if out_ch ();

  multicast_report_frame_builder_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mrfb_report_checker chk (
    .clk           (clk),
    .rst           (rst),
    .req           (in_ch),
    .frm           (out_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic endpoint_t make_endpoint(
    input logic        up,
    input logic        v6,
    input logic [47:0] mac,
    input logic [31:0] src4,
    input logic [63:0] s6hi,
    input logic [63:0] s6lo,
    input logic [31:0] g4,
    input logic [63:0] g6hi,
    input logic [63:0] g6lo
  );
    endpoint_t e;
    e = '{up, v6, mac, src4, s6hi, s6lo, g4, g6hi, g6lo};
    return e;
  endfunction

  function automatic logic [63:0] rand_edge64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic endpoint_t random_endpoint(input bit want_frame);
    endpoint_t e;
    e.up   = 1'b1;
    e.v6   = 1'($urandom_range(0, 1));
    e.mac  = 48'(rand_edge64());
    e.src4 = 32'(rand_edge64());
    e.s6hi = rand_edge64();
    e.s6lo = rand_edge64();
    e.g4   = 32'(rand_edge64());
    e.g6hi = rand_edge64();
    e.g6lo = rand_edge64();
    if ($urandom_range(0, 3) == 0) begin
      e.g4   = MDNS_V4;
      e.g6hi = MDNS_V6_HI;
      e.g6lo = MDNS_V6_LO;
    end
    if (want_frame) begin
      if (e.src4 == '0)
        e.src4 = 32'($urandom_range(1, 255));
      e.s6hi[63:54] = LINK_LOCAL_TOP;
    end else begin
      case ($urandom_range(0, 2))
        0: e.up = 1'b0;
        1: begin
          e.v6   = 1'b0;
          e.src4 = '0;
        end
        default: begin
          e.v6 = 1'b1;
          if (e.s6hi[63:54] == LINK_LOCAL_TOP)
            e.s6hi[63] = 1'b0;
        end
      endcase
    end
    return e;
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic offer(input endpoint_t e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.endpoint_up = e.up;
    in_ch.is_ipv6     = e.v6;
    in_ch.src_mac     = e.mac;
    in_ch.src_ipv4    = e.src4;
    in_ch.src_ipv6_hi = e.s6hi;
    in_ch.src_ipv6_lo = e.s6lo;
    in_ch.group_v4    = e.g4;
    in_ch.group_v6_hi = e.g6hi;
    in_ch.group_v6_lo = e.g6lo;
    in_ch.valid       = 1'b1;
    do
      @(posedge clk);
    while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin : receiver
    rx_mode_t mode;
    int       seg;
    int       span;
    int       hold;
    out_ch.ready = 1'b0;
    while (rst !== 1'b0)
      @(negedge clk);
    seg = 0;
    forever begin
      if (seg == 3) begin
        // long hold-off so the job queue fills and the input stalls
        out_ch.ready = 1'b0;
        for (hold = 0; hold < 400; hold++)
          @(negedge clk);
      end else begin
        mode = rx_mode_t'($urandom_range(0, 3));
        span = $urandom_range(16, 160);
        for (int i = 0; i < span; i++) begin
          case (mode)
            RX_STEADY:       out_ch.ready = 1'b1;
            RX_COIN:         out_ch.ready = 1'($urandom_range(0, 1));
            RX_SPARSE:       out_ch.ready = ($urandom_range(0, 7) == 0);
            RX_TWO_OF_THREE: out_ch.ready = (i % 3 != 0);
            default:         out_ch.ready = 1'b1;
          endcase
          @(negedge clk);
        end
      end
      seg++;
    end
  end

  initial begin : stimulus
    int items_sent;
    in_ch.valid       = 1'b0;
    in_ch.endpoint_up = 1'b0;
    in_ch.is_ipv6     = 1'b0;
    in_ch.src_mac     = '0;
    in_ch.src_ipv4    = '0;
    in_ch.src_ipv6_hi = '0;
    in_ch.src_ipv6_lo = '0;
    in_ch.group_v4    = '0;
    in_ch.group_v6_hi = '0;
    in_ch.group_v6_lo = '0;
    burst_left        = 0;
    rst               = 1'b1;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    offer(make_endpoint(1'b1, 1'b0, 48'h0211_2233_4455, 32'hc0a8_010a, '0, '0,
                        MDNS_V4, '0, '0));
    offer(make_endpoint(1'b1, 1'b1, 48'h0211_2233_4455, '0, 64'hfe80_0000_0000_0000,
                        64'h0211_22ff_fe33_4455, '0, MDNS_V6_HI, MDNS_V6_LO));
    offer(make_endpoint(1'b0, 1'b0, 48'h0211_2233_4455, 32'hc0a8_010a, '0, '0,
                        MDNS_V4, '0, '0));
    offer(make_endpoint(1'b0, 1'b1, 48'h0211_2233_4455, '0, 64'hfe80_0000_0000_0000,
                        64'h1, '0, MDNS_V6_HI, MDNS_V6_LO));
    offer(make_endpoint(1'b1, 1'b0, 48'h0211_2233_4455, '0, '0, '0, MDNS_V4, '0, '0));
    offer(make_endpoint(1'b1, 1'b1, 48'h0211_2233_4455, '0, 64'h2001_0db8_0000_0000,
                        64'h1, '0, MDNS_V6_HI, MDNS_V6_LO));
    offer(make_endpoint(1'b1, 1'b1, 48'h0211_2233_4455, '0, 64'hfec0_0000_0000_0000,
                        64'h1, '0, MDNS_V6_HI, MDNS_V6_LO));
    offer(make_endpoint(1'b1, 1'b1, 48'h0211_2233_4455, '0, 64'hfe7f_ffff_ffff_ffff,
                        64'h1, '0, MDNS_V6_HI, MDNS_V6_LO));
    offer(make_endpoint(1'b1, 1'b1, 48'h0211_2233_4455, '0, 64'hfebf_ffff_ffff_ffff,
                        64'h1, '0, MDNS_V6_HI, MDNS_V6_LO));
    offer(make_endpoint(1'b1, 1'b0, '1, '1, '1, '1, '1, '1, '1));
    offer(make_endpoint(1'b1, 1'b1, '1, '1, 64'hfebf_ffff_ffff_ffff, '1, '1, '1, '1));
    offer(make_endpoint(1'b1, 1'b0, '0, 32'h1, '0, '0, '0, '0, '0));
    offer(make_endpoint(1'b1, 1'b1, '0, '0, 64'hfe80_0000_0000_0000, '0, '0, '0, '0));
    offer(make_endpoint(1'b1, 1'b0, 48'h0a0b_0c0d_0e0f, 32'h0a00_0002, '0, '0,
                        32'h0a00_0001, '0, '0));
    offer(make_endpoint(1'b1, 1'b1, 48'h0a0b_0c0d_0e0f, '0, 64'hfe80_0000_0000_0000,
                        64'h2, '0, 64'h2001_0db8_0000_0000, 64'h1));
    offer(make_endpoint(1'b1, 1'b0, 48'h8000_0000_0001, 32'h8000_0000, '1, '1,
                        32'hefff_ffff, '1, '1));
    offer(make_endpoint(1'b1, 1'b1, 48'h8000_0000_0001, '0, 64'hfe80_0000_0000_0001,
                        64'h8000_0000_0000_0000, '0, 64'hff02_ffff_0000_0000,
                        64'hffff_ffff_0000_0000));

    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 20)
        offer(random_endpoint(1'b0));
      else
        offer(random_endpoint(1'b1));
      items_sent++;
    end
    in_ch.valid = 1'b0;

    while (pending_words != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
rtl/mrfb_pkg.sv
rtl/mrfb_in_if.sv
rtl/mrfb_out_if.sv
rtl/mrfb_front.sv
rtl/mrfb_queue.sv
rtl/mrfb_back.sv
rtl/multicast_report_frame_builder_top.sv
bench/mrfb_report_checker.sv
bench/tb_multicast_report_frame_builder_top.sv
